### sv/hsvcpd_pkg.sv
// ============================================================================
// HSV color presence detector package
// Shared widths, register indexes, reset values and controller types.
// ============================================================================
package hsvcpd_pkg;

    // Field widths.
    localparam int COLOR_BITS  = 8;
    localparam int COL_BITS    = 12;
    localparam int START_BITS  = 12;
    localparam int WIDTH_BITS  = 13;
    localparam int COUNT_BITS  = 22;
    localparam int CFG_DATA_BITS = 22;
    localparam int CFG_IDX_BITS  = 3;

    // Stream word widths, padded to whole bytes.
    localparam int S_TDATA_BITS = 40;
    localparam int M_TDATA_BITS = 24;

    // Divider geometry: dividend holds up to 661 * 255, divisor up to 510.
    localparam int DIVIDEND_BITS = 18;
    localparam int DIVISOR_BITS  = 9;
    localparam int DIV_STEPS     = DIVIDEND_BITS;
    localparam int DIV_CNT_BITS  = $clog2(DIV_STEPS);

    // Saturation numerator 510 * diff + v fits in 17 bits.
    localparam int SNUM_BITS = 17;
    localparam int HUE_BITS  = 9;
    localparam logic [HUE_BITS-1:0] HUE_WRAP = 9'd180;

    // Window edge: start + width needs one bit more than the width field.
    localparam int EDGE_BITS = WIDTH_BITS + 1;
    localparam int MAX_COLUMNS = 4096;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_START = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_WIDTH = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HUE_LOW      = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HUE_HIGH     = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SAT_LOW      = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_VAL_LOW      = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_THRESHOLD    = 3'd6;

    // Register values after reset.
    localparam logic [START_BITS-1:0]  RST_WINDOW_START = 12'd210;
    localparam logic [WIDTH_BITS-1:0]  RST_WINDOW_WIDTH = 13'd250;
    localparam logic [COLOR_BITS-1:0]  RST_HUE_LOW      = 8'd17;
    localparam logic [COLOR_BITS-1:0]  RST_HUE_HIGH     = 8'd30;
    localparam logic [COLOR_BITS-1:0]  RST_SAT_LOW      = 8'd67;
    localparam logic [COLOR_BITS-1:0]  RST_VAL_LOW      = 8'd78;
    localparam logic [COUNT_BITS-1:0]  RST_THRESHOLD    = 22'd5000;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_EVAL
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;   // capture the input word
        logic load_div;  // form operands and start both dividers
        logic step_div;  // one quotient bit in both dividers
        logic commit;    // update the count and, on frame end, the result
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last;      // captured word closes the frame
        logic out_free;  // result register can take a new word this cycle
    } sts_t;

endpackage

### sv/hsv_color_presence_detector.sv
// ============================================================================
// HSV color presence detector
// Counts pixels of a column strip that fall in an HSV color box per frame.
// ============================================================================
// Usage:
//   The s_ channel carries one pixel per word: blue, green, red and column in
//   s_tdata, with s_tlast marking the last pixel of a frame. Pixels inside
//   the configured column window are converted to HSV and counted when hue,
//   saturation and value lie within the configured limits.
//   On the last pixel of a frame one word leaves on the m_ channel with the
//   detection flag and the saturating match count, and the count restarts.
//   Each pixel is accepted, its operands are set up, the two restoring
//   dividers (saturation and hue, run in parallel) take 18 steps and the
//   count is updated; the next pixel is accepted only after that update.
//   A frame result is registered onto m_tvalid in that update step.
//   A waiting result does not stop the next pixels; only a further frame end
//   waits in the update step until the result register is free.
//   Write registers through cfg_we, cfg_index and cfg_wdata only while the
//   block is idle; the block does not enforce this. Reset restores the
//   default register values, clears the count and drops any pending result.
// ============================================================================
module hsv_color_presence_detector (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // Pixel stream.
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [hsvcpd_pkg::S_TDATA_BITS-1:0]   s_tdata,  // blue, green, red, column
    input  logic                                  s_tlast,  // frame_end
    // Result stream.
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [hsvcpd_pkg::M_TDATA_BITS-1:0]   m_tdata,  // detected, match_count
    // Register write port.
    input  logic                                  cfg_we,
    input  logic [hsvcpd_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [hsvcpd_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);

    hsvcpd_pkg::cmd_t cmd;
    hsvcpd_pkg::sts_t sts;

    hsvcpd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    hsvcpd_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

endmodule

### sv/hsvcpd_div.sv
// ============================================================================
// Restoring divider
// Unsigned division producing one quotient bit per step.
// ============================================================================
module hsvcpd_div (
    input  logic                                 aclk,
    input  logic                                 start,
    input  logic                                 step,
    input  logic [hsvcpd_pkg::DIVIDEND_BITS-1:0] dividend,
    input  logic [hsvcpd_pkg::DIVISOR_BITS-1:0]  divisor,
    output logic [hsvcpd_pkg::DIVIDEND_BITS-1:0] quotient
);

    logic [hsvcpd_pkg::DIVIDEND_BITS-1:0] quo_reg, quo_next;
    logic [hsvcpd_pkg::DIVISOR_BITS-1:0]  rem_reg, rem_next;
    logic [hsvcpd_pkg::DIVISOR_BITS-1:0]  den_reg, den_next;
    logic [hsvcpd_pkg::DIVISOR_BITS:0]    trial;
    logic                                 fits;

    // Shift the next dividend bit into the remainder and try a subtraction.
    always_comb begin
        trial    = {rem_reg, quo_reg[hsvcpd_pkg::DIVIDEND_BITS-1]};
        fits     = trial >= {1'b0, den_reg};
        quo_next = quo_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        if (start) begin
            quo_next = dividend;
            rem_next = '0;
            den_next = divisor;
        end else if (step) begin
            quo_next = {quo_reg[hsvcpd_pkg::DIVIDEND_BITS-2:0], fits};
            if (fits) begin
                rem_next = hsvcpd_pkg::DIVISOR_BITS'(trial - {1'b0, den_reg});
            end else begin
                rem_next = hsvcpd_pkg::DIVISOR_BITS'(trial);
            end
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign quotient = quo_reg;

endmodule

### sv/hsvcpd_dp.sv
// ============================================================================
// HSV color presence detector datapath
// Configuration registers, HSV conversion, match count and result register.
// ============================================================================
module hsvcpd_dp (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  hsvcpd_pkg::cmd_t                      cmd,
    output hsvcpd_pkg::sts_t                      sts,
    input  logic [hsvcpd_pkg::S_TDATA_BITS-1:0]   s_tdata,
    input  logic                                  s_tlast,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [hsvcpd_pkg::M_TDATA_BITS-1:0]   m_tdata,
    input  logic                                  cfg_we,
    input  logic [hsvcpd_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [hsvcpd_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);

    localparam int CB = hsvcpd_pkg::COLOR_BITS;
    localparam int NB = hsvcpd_pkg::COUNT_BITS;

    // Configuration registers.
    logic [hsvcpd_pkg::START_BITS-1:0] win_start_reg;
    logic [hsvcpd_pkg::WIDTH_BITS-1:0] win_width_reg;
    logic [CB-1:0]                     hue_low_reg, hue_high_reg;
    logic [CB-1:0]                     sat_low_reg, val_low_reg;
    logic [NB-1:0]                     threshold_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_start_reg <= hsvcpd_pkg::RST_WINDOW_START;
            win_width_reg <= hsvcpd_pkg::RST_WINDOW_WIDTH;
            hue_low_reg   <= hsvcpd_pkg::RST_HUE_LOW;
            hue_high_reg  <= hsvcpd_pkg::RST_HUE_HIGH;
            sat_low_reg   <= hsvcpd_pkg::RST_SAT_LOW;
            val_low_reg   <= hsvcpd_pkg::RST_VAL_LOW;
            threshold_reg <= hsvcpd_pkg::RST_THRESHOLD;
        end else if (cfg_we) begin
            unique case (cfg_index)
                hsvcpd_pkg::CFG_WINDOW_START: win_start_reg <= cfg_wdata[11:0];
                hsvcpd_pkg::CFG_WINDOW_WIDTH: win_width_reg <= cfg_wdata[12:0];
                hsvcpd_pkg::CFG_HUE_LOW:      hue_low_reg   <= cfg_wdata[7:0];
                hsvcpd_pkg::CFG_HUE_HIGH:     hue_high_reg  <= cfg_wdata[7:0];
                hsvcpd_pkg::CFG_SAT_LOW:      sat_low_reg   <= cfg_wdata[7:0];
                hsvcpd_pkg::CFG_VAL_LOW:      val_low_reg   <= cfg_wdata[7:0];
                hsvcpd_pkg::CFG_THRESHOLD:    threshold_reg <= cfg_wdata[21:0];
                default: ;
            endcase
        end
    end

    // Input word capture.
    logic [CB-1:0]                   blue_reg, green_reg, red_reg;
    logic [hsvcpd_pkg::COL_BITS-1:0] col_reg;
    logic                            last_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            blue_reg  <= s_tdata[7:0];
            green_reg <= s_tdata[15:8];
            red_reg   <= s_tdata[23:16];
            col_reg   <= s_tdata[35:24];
            last_reg  <= s_tlast;
        end
    end

    // Max, min and the two dividends and divisors.
    logic [CB-1:0]                          v_c, mn_c, diff_c;
    logic [CB-1:0]                          hue_add, hue_sub;
    logic [9:0]                             hue_k;
    logic [hsvcpd_pkg::SNUM_BITS-1:0]       s_num;
    logic [hsvcpd_pkg::DIVIDEND_BITS-1:0]   h_num;
    logic [hsvcpd_pkg::EDGE_BITS-1:0]       win_end;
    logic                                   inside_c;

    always_comb begin
        v_c  = blue_reg;
        mn_c = blue_reg;
        if (green_reg > v_c)  v_c  = green_reg;
        if (red_reg > v_c)    v_c  = red_reg;
        if (green_reg < mn_c) mn_c = green_reg;
        if (red_reg < mn_c)   mn_c = red_reg;
        diff_c = v_c - mn_c;

        s_num = hsvcpd_pkg::SNUM_BITS'(diff_c) * hsvcpd_pkg::SNUM_BITS'(510)
              + hsvcpd_pkg::SNUM_BITS'(v_c);

        // Sector offset of 360 degrees plus the rounding term, all per diff.
        priority if (v_c == red_reg) begin
            hue_add = green_reg;
            hue_sub = blue_reg;
            hue_k   = 10'd361;
        end else if (v_c == green_reg) begin
            hue_add = blue_reg;
            hue_sub = red_reg;
            hue_k   = 10'd481;
        end else begin
            hue_add = red_reg;
            hue_sub = green_reg;
            hue_k   = 10'd601;
        end
        h_num = hsvcpd_pkg::DIVIDEND_BITS'(hue_add) * hsvcpd_pkg::DIVIDEND_BITS'(60)
              + hsvcpd_pkg::DIVIDEND_BITS'(diff_c) * hsvcpd_pkg::DIVIDEND_BITS'(hue_k)
              - hsvcpd_pkg::DIVIDEND_BITS'(hue_sub) * hsvcpd_pkg::DIVIDEND_BITS'(60);

        win_end  = hsvcpd_pkg::EDGE_BITS'(win_start_reg)
                 + hsvcpd_pkg::EDGE_BITS'(win_width_reg);
        inside_c = (col_reg >= win_start_reg)
                && (hsvcpd_pkg::EDGE_BITS'(col_reg) < win_end)
                && (32'(col_reg) < hsvcpd_pkg::MAX_COLUMNS);
    end

    // Value, window flag and the flags that override the divider results, kept for the evaluation step.
    logic [CB-1:0] v_reg;
    logic          v_zero_reg, diff_zero_reg, inside_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_div) begin
            v_reg         <= v_c;
            v_zero_reg    <= (v_c == '0);
            diff_zero_reg <= (diff_c == '0);
            inside_reg    <= inside_c;
        end
    end

    // Saturation and hue dividers run side by side.
    logic [hsvcpd_pkg::DIVIDEND_BITS-1:0] s_quo, h_quo;

    hsvcpd_div u_sat_div (
        .aclk     (aclk),
        .start    (cmd.load_div),
        .step     (cmd.step_div),
        .dividend (hsvcpd_pkg::DIVIDEND_BITS'(s_num)),
        .divisor  ({v_c, 1'b0}),
        .quotient (s_quo)
    );

    hsvcpd_div u_hue_div (
        .aclk     (aclk),
        .start    (cmd.load_div),
        .step     (cmd.step_div),
        .dividend (h_num),
        .divisor  ({diff_c, 1'b0}),
        .quotient (h_quo)
    );

    // Threshold test and saturating count update.
    logic [CB-1:0]                   sat_c;
    logic [hsvcpd_pkg::HUE_BITS-1:0] hue_raw, hue_c;
    logic                            match_c;
    logic [NB-1:0]                   cnt_reg, cnt_next, cnt_upd;
    logic                            out_valid_reg, out_valid_next;
    logic                            det_reg, det_next;
    logic [NB-1:0]                   out_cnt_reg, out_cnt_next;

    always_comb begin
        sat_c   = v_zero_reg ? '0 : s_quo[CB-1:0];
        hue_raw = diff_zero_reg ? '0 : h_quo[hsvcpd_pkg::HUE_BITS-1:0];
        hue_c   = (hue_raw >= hsvcpd_pkg::HUE_WRAP) ? hue_raw - hsvcpd_pkg::HUE_WRAP
                                                     : hue_raw;
        match_c = inside_reg
               && (hue_c >= hsvcpd_pkg::HUE_BITS'(hue_low_reg))
               && (hue_c <= hsvcpd_pkg::HUE_BITS'(hue_high_reg))
               && (sat_c >= sat_low_reg)
               && (v_reg >= val_low_reg);

        cnt_upd = (match_c && (cnt_reg != '1)) ? cnt_reg + 1'b1 : cnt_reg;

        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !m_tready;
        det_next       = det_reg;
        out_cnt_next   = out_cnt_reg;
        if (cmd.commit) begin
            if (last_reg) begin
                cnt_next       = '0;
                out_valid_next = 1'b1;
                det_next       = cnt_upd > threshold_reg;
                out_cnt_next   = cnt_upd;
            end else begin
                cnt_next = cnt_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        det_reg     <= det_next;
        out_cnt_reg <= out_cnt_next;
    end

    assign sts.last     = last_reg;
    assign sts.out_free = !out_valid_reg || m_tready;
    assign m_tvalid     = out_valid_reg;
    assign m_tdata      = {1'b0, out_cnt_reg, det_reg};

endmodule

### sv/hsvcpd_ctrl.sv
// ============================================================================
// HSV color presence detector controller
// Sequences capture, operand setup, divider steps and the count update.
// ============================================================================
module hsvcpd_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  hsvcpd_pkg::sts_t sts,
    output hsvcpd_pkg::cmd_t cmd
);

    hsvcpd_pkg::state_t                   state_reg, state_next;
    logic [hsvcpd_pkg::DIV_CNT_BITS-1:0]  iter_reg, iter_next;
    logic                                 div_done;

    assign div_done = (iter_reg == hsvcpd_pkg::DIV_CNT_BITS'(hsvcpd_pkg::DIV_STEPS - 1));

    // Next state and step counter.
    always_comb begin
        state_next = state_reg;
        iter_next  = iter_reg;
        unique case (state_reg)
            hsvcpd_pkg::ST_IDLE: begin
                if (s_tvalid) state_next = hsvcpd_pkg::ST_PREP;
            end
            hsvcpd_pkg::ST_PREP: begin
                iter_next  = '0;
                state_next = hsvcpd_pkg::ST_DIV;
            end
            hsvcpd_pkg::ST_DIV: begin
                iter_next = iter_reg + 1'b1;
                if (div_done) state_next = hsvcpd_pkg::ST_EVAL;
            end
            hsvcpd_pkg::ST_EVAL: begin
                // A frame result must wait for room in the result register.
                if (!sts.last || sts.out_free) state_next = hsvcpd_pkg::ST_IDLE;
            end
            default: state_next = hsvcpd_pkg::ST_IDLE;
        endcase
    end

    // Commands for the datapath.
    always_comb begin
        s_tready = 1'b0;
        cmd      = '0;
        unique case (state_reg)
            hsvcpd_pkg::ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.load_in = s_tvalid;
            end
            hsvcpd_pkg::ST_PREP: cmd.load_div = 1'b1;
            hsvcpd_pkg::ST_DIV:  cmd.step_div = 1'b1;
            hsvcpd_pkg::ST_EVAL: cmd.commit   = !sts.last || sts.out_free;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= hsvcpd_pkg::ST_IDLE;
            iter_reg  <= '0;
        end else begin
            state_reg <= state_next;
            iter_reg  <= iter_next;
        end
    end

endmodule

### dv/hsv_color_presence_detector_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// HSV color presence detector testbench
// Streams BGR pixel words through the detector under a series of register
// settings and checks every frame result word against a cycle-free predictor
// of the HSV conversion, the column window and the saturating match count.
// ============================================================================
module hsv_color_presence_detector_tb;

    // Index with no register behind it; writes to it must change nothing.
    localparam logic [hsvcpd_pkg::CFG_IDX_BITS-1:0] CFG_UNUSED = 3'd7;
    localparam int SETTLE_CYCLES = 30;
    localparam int PHASE_COUNT   = 14;
    localparam int PHASE_PIXELS  = 66;

    typedef struct {
        logic [hsvcpd_pkg::COLOR_BITS-1:0] b;
        logic [hsvcpd_pkg::COLOR_BITS-1:0] g;
        logic [hsvcpd_pkg::COLOR_BITS-1:0] r;
        logic [hsvcpd_pkg::COL_BITS-1:0]   col;
        logic                              last;
    } pixel_t;

    typedef struct {
        logic [hsvcpd_pkg::START_BITS-1:0] start;
        logic [hsvcpd_pkg::WIDTH_BITS-1:0] width;
        logic [hsvcpd_pkg::COLOR_BITS-1:0] hue_lo;
        logic [hsvcpd_pkg::COLOR_BITS-1:0] hue_hi;
        logic [hsvcpd_pkg::COLOR_BITS-1:0] sat_lo;
        logic [hsvcpd_pkg::COLOR_BITS-1:0] val_lo;
        logic [hsvcpd_pkg::COUNT_BITS-1:0] thr;
    } strip_cfg_t;

    typedef struct {
        logic                              detected;
        logic [hsvcpd_pkg::COUNT_BITS-1:0] count;
    } frame_result_t;

    // Predicts frame results from accepted pixel words and checks result words.
    class presence_predictor;
        strip_cfg_t                        regs;
        logic [hsvcpd_pkg::COUNT_BITS-1:0] match_total;
        frame_result_t                     frames_due[$];
        int                                pixels_seen;
        int                                frames_checked;
        int                                frames_detected;
        int                                mismatches;

        function void clear();
            regs.start  = hsvcpd_pkg::RST_WINDOW_START;
            regs.width  = hsvcpd_pkg::RST_WINDOW_WIDTH;
            regs.hue_lo = hsvcpd_pkg::RST_HUE_LOW;
            regs.hue_hi = hsvcpd_pkg::RST_HUE_HIGH;
            regs.sat_lo = hsvcpd_pkg::RST_SAT_LOW;
            regs.val_lo = hsvcpd_pkg::RST_VAL_LOW;
            regs.thr    = hsvcpd_pkg::RST_THRESHOLD;
            match_total = '0;
            frames_due.delete();
        endfunction

        // Each register keeps only its own low bits.
        function void set_reg(logic [hsvcpd_pkg::CFG_IDX_BITS-1:0] idx,
                              logic [hsvcpd_pkg::CFG_DATA_BITS-1:0] val);
            case (idx)
                hsvcpd_pkg::CFG_WINDOW_START: regs.start  = val[hsvcpd_pkg::START_BITS-1:0];
                hsvcpd_pkg::CFG_WINDOW_WIDTH: regs.width  = val[hsvcpd_pkg::WIDTH_BITS-1:0];
                hsvcpd_pkg::CFG_HUE_LOW:      regs.hue_lo = val[hsvcpd_pkg::COLOR_BITS-1:0];
                hsvcpd_pkg::CFG_HUE_HIGH:     regs.hue_hi = val[hsvcpd_pkg::COLOR_BITS-1:0];
                hsvcpd_pkg::CFG_SAT_LOW:      regs.sat_lo = val[hsvcpd_pkg::COLOR_BITS-1:0];
                hsvcpd_pkg::CFG_VAL_LOW:      regs.val_lo = val[hsvcpd_pkg::COLOR_BITS-1:0];
                hsvcpd_pkg::CFG_THRESHOLD:    regs.thr    = val[hsvcpd_pkg::COUNT_BITS-1:0];
                default: ;
            endcase
        endfunction

        // HSV conversion with round-half-up on both divisions.
        function bit color_in_box(logic [hsvcpd_pkg::COLOR_BITS-1:0] b,
                                  logic [hsvcpd_pkg::COLOR_BITS-1:0] g,
                                  logic [hsvcpd_pkg::COLOR_BITS-1:0] r);
            int bi, gi, ri, v, mn, diff, s, h, num;
            bi = int'(b);
            gi = int'(g);
            ri = int'(r);
            v  = (bi > gi) ? bi : gi;
            v  = (ri > v) ? ri : v;
            mn = (bi < gi) ? bi : gi;
            mn = (ri < mn) ? ri : mn;
            diff = v - mn;
            s = (v == 0) ? 0 : (510 * diff + v) / (2 * v);
            if (diff == 0) begin
                h = 0;
            end else begin
                if (v == ri)
                    num = gi - bi;
                else if (v == gi)
                    num = bi - ri + 2 * diff;
                else
                    num = ri - gi + 4 * diff;
                // The 360-degree offset keeps the dividend positive.
                h = (60 * num + 361 * diff) / (2 * diff);
                if (h >= 180)
                    h -= 180;
            end
            return h >= int'(regs.hue_lo) && h <= int'(regs.hue_hi) &&
                   s >= int'(regs.sat_lo) && v >= int'(regs.val_lo);
        endfunction

        function void note_pixel(pixel_t p);
            int col, lo, w;
            bit hit;
            frame_result_t res;
            pixels_seen++;
            col = int'(p.col);
            lo  = int'(regs.start);
            w   = int'(regs.width);
            hit = col >= lo && col < lo + w && col < hsvcpd_pkg::MAX_COLUMNS;
            if (hit && color_in_box(p.b, p.g, p.r) && match_total != '1)
                match_total++;
            if (p.last) begin
                res.detected = (match_total > regs.thr);
                res.count    = match_total;
                frames_due.push_back(res);
                match_total = '0;
            end
        endfunction

        function void flag(string what);
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR at %0t ns: %s", $time, what);
        endfunction

        function void check_frame_result(logic detected,
                                         logic [hsvcpd_pkg::COUNT_BITS-1:0] count);
            frame_result_t want;
            if (frames_due.size() == 0) begin
                flag($sformatf("result word with no frame pending: detected=%0b count=%0d",
                               detected, count));
                return;
            end
            want = frames_due.pop_front();
            frames_checked++;
            if (want.detected)
                frames_detected++;
            if (detected !== want.detected)
                flag($sformatf("frame %0d detected: expected %0b, got %0b",
                               frames_checked, want.detected, detected));
            if (count !== want.count)
                flag($sformatf("frame %0d match_count: expected %0d, got %0d",
                               frames_checked, want.count, count));
        endfunction
    endclass

    logic                                 aclk      = 1'b0;
    logic                                 aresetn   = 1'b0;
    logic                                 s_tvalid  = 1'b0;
    logic                                 s_tready;
    logic [hsvcpd_pkg::S_TDATA_BITS-1:0]  s_tdata   = '0;
    logic                                 s_tlast   = 1'b0;
    logic                                 m_tvalid;
    logic                                 m_tready  = 1'b0;
    logic [hsvcpd_pkg::M_TDATA_BITS-1:0]  m_tdata;
    logic                                 cfg_we    = 1'b0;
    logic [hsvcpd_pkg::CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [hsvcpd_pkg::CFG_DATA_BITS-1:0] cfg_wdata = '0;

    presence_predictor board;
    bit                tx_burst;
    int                settings_applied;

    hsv_color_presence_detector dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // 100 MHz clock.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic pixel_t mk(int b, int g, int r, int col, bit last);
        pixel_t p;
        p.b    = hsvcpd_pkg::COLOR_BITS'(b);
        p.g    = hsvcpd_pkg::COLOR_BITS'(g);
        p.r    = hsvcpd_pkg::COLOR_BITS'(r);
        p.col  = hsvcpd_pkg::COL_BITS'(col);
        p.last = last;
        return p;
    endfunction

    // Random pixel: grays, saturated corners, warm tones and plain noise,
    // with most columns close to the current window.
    function automatic pixel_t pick_pixel(bit last, int start, int width);
        pixel_t p;
        int lo, hi, mode;
        mode = $urandom_range(0, 9);
        p.b  = hsvcpd_pkg::COLOR_BITS'($urandom);
        p.g  = hsvcpd_pkg::COLOR_BITS'($urandom);
        p.r  = hsvcpd_pkg::COLOR_BITS'($urandom);
        case (mode)
            0: begin
                p.g = p.b;
                p.r = p.b;
            end
            1: begin
                p.b = {hsvcpd_pkg::COLOR_BITS{p.b[0]}};
                p.g = {hsvcpd_pkg::COLOR_BITS{p.g[0]}};
                p.r = {hsvcpd_pkg::COLOR_BITS{p.r[0]}};
            end
            2, 3, 4: begin
                p.r = hsvcpd_pkg::COLOR_BITS'($urandom_range(150, 255));
                p.b = hsvcpd_pkg::COLOR_BITS'($urandom_range(0, int'(p.r) / 3));
                p.g = hsvcpd_pkg::COLOR_BITS'($urandom_range(int'(p.b), int'(p.r)));
            end
            default: ;
        endcase
        lo = (start > 3) ? start - 3 : 0;
        hi = start + width + 3;
        if (hi > hsvcpd_pkg::MAX_COLUMNS - 1)
            hi = hsvcpd_pkg::MAX_COLUMNS - 1;
        if ($urandom_range(0, 9) < 7)
            p.col = hsvcpd_pkg::COL_BITS'($urandom_range(lo, hi));
        else
            p.col = hsvcpd_pkg::COL_BITS'($urandom);
        p.last = last;
        return p;
    endfunction

    // Settings for one phase: fixed corner cases first, then random ones.
    function automatic strip_cfg_t make_cfg(int k);
        strip_cfg_t c;
        int lo, hi;
        c.start  = hsvcpd_pkg::RST_WINDOW_START;
        c.width  = hsvcpd_pkg::RST_WINDOW_WIDTH;
        c.hue_lo = hsvcpd_pkg::RST_HUE_LOW;
        c.hue_hi = hsvcpd_pkg::RST_HUE_HIGH;
        c.sat_lo = hsvcpd_pkg::RST_SAT_LOW;
        c.val_lo = hsvcpd_pkg::RST_VAL_LOW;
        c.thr    = hsvcpd_pkg::COUNT_BITS'($urandom_range(0, 10));
        case (k)
            // Everything passes: full frame, all hues, no color floor.
            0: begin
                c.start  = '0;
                c.width  = hsvcpd_pkg::WIDTH_BITS'(hsvcpd_pkg::MAX_COLUMNS);
                c.hue_lo = '0;
                c.hue_hi = 8'hFF;
                c.sat_lo = '0;
                c.val_lo = '0;
                c.thr    = hsvcpd_pkg::COUNT_BITS'($urandom_range(0, 20));
            end
            // Empty window with all-zero registers.
            1: begin
                c.start  = '0;
                c.width  = '0;
                c.hue_lo = '0;
                c.hue_hi = '0;
                c.sat_lo = '0;
                c.val_lo = '0;
                c.thr    = '0;
            end
            // Window runs past the frame edge, threshold at its top.
            2: begin
                c.start  = hsvcpd_pkg::START_BITS'(hsvcpd_pkg::MAX_COLUMNS - 1);
                c.width  = hsvcpd_pkg::WIDTH_BITS'(hsvcpd_pkg::MAX_COLUMNS);
                c.hue_lo = '0;
                c.hue_hi = 8'hFF;
                c.sat_lo = '0;
                c.val_lo = '0;
                c.thr    = '1;
            end
            // Inverted hue range.
            3: begin
                c.start  = '0;
                c.width  = 13'd1000;
                c.hue_lo = 8'd100;
                c.hue_hi = 8'd20;
                c.sat_lo = '0;
                c.val_lo = '0;
            end
            // Hue bounds above the hue range, strict color floors.
            4: begin
                c.start  = 12'd4000;
                c.width  = 13'd200;
                c.hue_lo = 8'd180;
                c.hue_hi = 8'd200;
                c.sat_lo = 8'hFF;
                c.val_lo = 8'hFF;
            end
            // Reset values with a reachable threshold.
            5: ;
            default: begin
                c.start = hsvcpd_pkg::START_BITS'(($urandom_range(0, 3) == 0)
                              ? $urandom_range(0, hsvcpd_pkg::MAX_COLUMNS - 1)
                              : $urandom_range(0, 600));
                c.width = hsvcpd_pkg::WIDTH_BITS'(($urandom_range(0, 7) == 0)
                              ? $urandom_range(0, hsvcpd_pkg::MAX_COLUMNS)
                              : $urandom_range(1, 400));
                lo = $urandom_range(0, 179);
                hi = lo + $urandom_range(0, 70);
                c.hue_lo = hsvcpd_pkg::COLOR_BITS'(lo);
                c.hue_hi = hsvcpd_pkg::COLOR_BITS'((hi > 255) ? 255 : hi);
                c.sat_lo = hsvcpd_pkg::COLOR_BITS'(($urandom_range(0, 3) == 0)
                               ? $urandom_range(0, 255) : $urandom_range(0, 80));
                c.val_lo = hsvcpd_pkg::COLOR_BITS'(($urandom_range(0, 3) == 0)
                               ? $urandom_range(0, 255) : $urandom_range(0, 80));
                c.thr = hsvcpd_pkg::COUNT_BITS'(($urandom_range(0, 7) == 0)
                            ? $urandom_range(0, 4194303) : $urandom_range(0, 25));
            end
        endcase
        return c;
    endfunction

    // Fills the bits above a register's width with noise when asked.
    function automatic logic [hsvcpd_pkg::CFG_DATA_BITS-1:0] with_junk(
        logic [hsvcpd_pkg::CFG_DATA_BITS-1:0] v, int bits, bit junk);
        logic [hsvcpd_pkg::CFG_DATA_BITS-1:0] noise;
        noise = hsvcpd_pkg::CFG_DATA_BITS'($urandom);
        if (!junk)
            return v;
        return v | (noise << bits);
    endfunction

    // One register write; cfg_we stays high for back-to-back writes.
    task automatic write_reg(logic [hsvcpd_pkg::CFG_IDX_BITS-1:0] idx,
                             logic [hsvcpd_pkg::CFG_DATA_BITS-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        board.set_reg(idx, val);
    endtask

    task automatic apply_config(strip_cfg_t c);
        bit junk;
        junk = bit'($urandom_range(0, 1));
        write_reg(hsvcpd_pkg::CFG_WINDOW_START,
                  with_junk(hsvcpd_pkg::CFG_DATA_BITS'(c.start), hsvcpd_pkg::START_BITS, junk));
        write_reg(hsvcpd_pkg::CFG_WINDOW_WIDTH,
                  with_junk(hsvcpd_pkg::CFG_DATA_BITS'(c.width), hsvcpd_pkg::WIDTH_BITS, junk));
        write_reg(hsvcpd_pkg::CFG_HUE_LOW,
                  with_junk(hsvcpd_pkg::CFG_DATA_BITS'(c.hue_lo), hsvcpd_pkg::COLOR_BITS, junk));
        write_reg(hsvcpd_pkg::CFG_HUE_HIGH,
                  with_junk(hsvcpd_pkg::CFG_DATA_BITS'(c.hue_hi), hsvcpd_pkg::COLOR_BITS, junk));
        write_reg(hsvcpd_pkg::CFG_SAT_LOW,
                  with_junk(hsvcpd_pkg::CFG_DATA_BITS'(c.sat_lo), hsvcpd_pkg::COLOR_BITS, junk));
        write_reg(hsvcpd_pkg::CFG_VAL_LOW,
                  with_junk(hsvcpd_pkg::CFG_DATA_BITS'(c.val_lo), hsvcpd_pkg::COLOR_BITS, junk));
        write_reg(hsvcpd_pkg::CFG_THRESHOLD, c.thr);
        if (junk)
            write_reg(CFG_UNUSED, hsvcpd_pkg::CFG_DATA_BITS'($urandom));
        cfg_we <= 1'b0;
        settings_applied++;
    endtask

    // Offers one pixel word after a random gap and waits for its acceptance.
    task automatic send_pixel(pixel_t p);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, p.col, p.r, p.g, p.b};
        s_tlast  <= p.last;
        @(posedge aclk);
        while (s_tready !== 1'b1)
            @(posedge aclk);
        board.note_pixel(p);
    endtask

    // Drains all pending results, then lets a pixel still in flight finish.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (board.frames_due.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Frames of random length until the phase budget is spent.
    task automatic run_phase(int budget);
        int left, flen, i;
        left = budget;
        while (left > 0) begin
            flen = $urandom_range(1, 40);
            if (flen > left)
                flen = left;
            tx_burst = ($urandom_range(0, 3) == 0);
            for (i = 0; i < flen; i++)
                send_pixel(pick_pixel(i == flen - 1, int'(board.regs.start),
                                      int'(board.regs.width)));
            left -= flen;
        end
    endtask

    // Result side: random stall before each word, sometimes none.
    initial begin : result_sink
        int stall;
        wait (aresetn === 1'b1);
        forever begin
            stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 11);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (m_tvalid !== 1'b1)
                @(posedge aclk);
            board.check_frame_result(m_tdata[0], m_tdata[hsvcpd_pkg::COUNT_BITS:1]);
        end
    end

    // Main sequence: directed pixels at reset settings, then setting phases.
    initial begin : stimulus
        int k;
        board = new();
        board.clear();
        settings_applied = 1;
        tx_burst = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Black, white and gray; window edges; frame edge columns.
        send_pixel(mk(0, 0, 0, 210, 0));
        send_pixel(mk(255, 255, 255, 300, 0));
        send_pixel(mk(128, 128, 128, 459, 0));
        send_pixel(mk(0, 200, 255, 210, 0));
        send_pixel(mk(0, 200, 255, 209, 0));
        send_pixel(mk(0, 200, 255, 460, 0));
        send_pixel(mk(0, 200, 255, 459, 0));
        // Hue that rounds up to the wrap point, half-way hue and saturation.
        send_pixel(mk(1, 0, 255, 300, 0));
        send_pixel(mk(0, 1, 60, 300, 0));
        send_pixel(mk(1, 1, 2, 300, 0));
        send_pixel(mk(0, 255, 0, 300, 0));
        send_pixel(mk(255, 0, 0, 0, 0));
        send_pixel(mk(0, 0, 0, 4095, 0));
        send_pixel(mk(255, 255, 255, 4095, 1));
        // Single-pixel frame.
        tx_burst = 1'b1;
        send_pixel(mk(0, 180, 230, 250, 1));
        // Hue, saturation and value right on their limits.
        send_pixel(mk(10, 150, 240, 300, 0));
        send_pixel(mk(0, 255, 255, 400, 0));
        send_pixel(mk(0, 145, 255, 420, 0));
        tx_burst = 1'b0;
        send_pixel(mk(188, 230, 255, 300, 0));
        send_pixel(mk(20, 60, 78, 300, 1));

        for (k = 0; k < PHASE_COUNT; k++) begin
            settle();
            apply_config(make_cfg(k));
            run_phase(PHASE_PIXELS);
        end
        settle();

        $display("Covered %0d pixel words in %0d frames under %0d register settings.",
                 board.pixels_seen, board.frames_checked, settings_applied);
        $display("%0d frames detected, %0d mismatches.",
                 board.frames_detected, board.mismatches);
        if (board.mismatches == 0 && board.frames_due.size() == 0) begin
            $display("hsv_color_presence_detector_tb OK");
        end else begin
            $display("hsv_color_presence_detector_tb NOT OK");
        end
        $finish;
    end

    // Hard stop far beyond the slowest correct run.
    initial begin : watchdog
        #5_000_000;
        $display("Timed out with %0d frames still pending.", board.frames_due.size());
        $display("hsv_color_presence_detector_tb NOT OK");
        $finish;
    end

endmodule
